// ----- sv/qppsn_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qppsn_pkg
// Shared types and constants of the queue pair psn state table.
// ----------------------------------------------------------------------------
package qppsn_pkg;

  localparam int unsigned CMD_BITS    = 3;
  localparam int unsigned QP_IN_BITS  = 9;
  localparam int unsigned QP_IN_MAX   = (2 ** QP_IN_BITS) - 1;
  localparam int unsigned RETRY_BITS  = 4;
  localparam int unsigned PORT_BITS   = 2;

  localparam logic [RETRY_BITS-1:0] SETUP_RETRY = 4'hF;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_RX_ACK_WR  = 3'd0,
    CMD_RX_EPSN_WR = 3'd1,
    CMD_RX_ACK_RD  = 3'd2,
    CMD_RX_EPSN_RD = 3'd3,
    CMD_TX_WR      = 3'd4,
    CMD_TX_RD      = 3'd5,
    CMD_SETUP      = 3'd6,
    CMD_ENTRY_RD   = 3'd7
  } cmd_e;

  typedef enum logic [PORT_BITS-1:0] {
    PORT_RX = 2'd0,
    PORT_TX = 2'd1,
    PORT_IF = 2'd2
  } port_e;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_RX_ACK,
    RD_RX_EPSN,
    RD_ENTRY
  } rd_kind_e;

  // per-field write enables of one table entry
  typedef struct packed {
    logic epsn;
    logic old_out;
    logic next;
    logic unack;
    logic valid;
    logic retry;
  } wr_en_t;

  typedef struct packed {
    wr_en_t   we;
    rd_kind_e rd;
    port_e    port;
  } op_ctrl_t;

endpackage

// ----- sv/queue_pair_psn_state_table_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// queue_pair_psn_state_table_unit
// Per queue pair psn state table: setup, field writes and rx or whole-entry
// reads, with a decoder front end and a memory back end.
// ----------------------------------------------------------------------------
// channel | dir | tdata, low bits first                              | tuser
// s_axis  | in  | queue_pair, psn_value, remote_psn_value,           | command
//         |     | retry_value, zero pad to bytes                     |
// m_axis  | out | rx_first_psn, rx_second_psn, rx_third_psn,         | dest_port
//         |     | rx_retry, entry_resp_epsn, entry_resp_old_out,     |
//         |     | entry_req_next, entry_req_unack, entry_req_valid,  |
//         |     | entry_retry, zero pad to bytes                     |
//
// one item per cycle sustained while m_axis_tready stays high, set by the single
// table access per cycle; a reply passes the two-entry queue, the registered read
// and the reply register; a write lands as it leaves the queue and is seen by any later read
// table entries are not cleared at reset; reset only empties the pipeline
// a stall on m_axis holds the reply register, then the read stage, then the
// two-entry queue and s_axis_tready; writes keep draining meanwhile
// ----------------------------------------------------------------------------
module queue_pair_psn_state_table_unit #(
  parameter int unsigned QP_COUNT = 512,
  parameter int unsigned PSN_BITS = 24
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // queue_pair, psn_value, remote_psn_value, retry_value
  input  logic [((qppsn_pkg::QP_IN_BITS + 2 * PSN_BITS + qppsn_pkg::RETRY_BITS + 7) / 8) * 8 - 1:0]
                                                 s_axis_tdata,
  // command
  input  logic [qppsn_pkg::CMD_BITS-1:0]         s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // rx_first_psn, rx_second_psn, rx_third_psn, rx_retry, entry_resp_epsn,
  // entry_resp_old_out, entry_req_next, entry_req_unack, entry_req_valid,
  // entry_retry
  output logic [((8 * PSN_BITS + 2 * qppsn_pkg::RETRY_BITS + 7) / 8) * 8 - 1:0]
                                                 m_axis_tdata,
  // dest_port
  output logic [qppsn_pkg::PORT_BITS-1:0]        m_axis_tuser
);

  localparam int unsigned QP_BITS  = (QP_COUNT > 1) ? $clog2(QP_COUNT) : 1;
  localparam int unsigned OUT_W    = ((8 * PSN_BITS + 2 * qppsn_pkg::RETRY_BITS + 7) / 8) * 8;
  localparam int unsigned OFF_PSN  = qppsn_pkg::QP_IN_BITS;
  localparam int unsigned OFF_RPSN = OFF_PSN + PSN_BITS;
  localparam int unsigned OFF_RTY  = OFF_RPSN + PSN_BITS;
  localparam int unsigned Q_W      = $bits(qppsn_pkg::op_ctrl_t) + QP_BITS + 2 * PSN_BITS
                                     + qppsn_pkg::RETRY_BITS;

  qppsn_pkg::op_ctrl_t              fr_ctrl, bk_ctrl;
  logic [QP_BITS-1:0]               fr_idx, bk_idx;
  logic [PSN_BITS-1:0]              fr_loc, bk_loc, fr_req, bk_req;
  logic [qppsn_pkg::RETRY_BITS-1:0] fr_retry, bk_retry;
  logic [Q_W-1:0]                   q_push_data, q_pop_data;
  logic                             q_pop_valid, q_pop_ready;

  qppsn_pkg::port_e                 out_port;
  logic [PSN_BITS-1:0]              rx_first, rx_second, rx_third;
  logic [qppsn_pkg::RETRY_BITS-1:0] rx_retry, ent_retry;
  logic [PSN_BITS-1:0]              ent_epsn, ent_old_out, ent_next, ent_unack, ent_valid;

  qppsn_front #(
    .QP_COUNT (QP_COUNT),
    .PSN_BITS (PSN_BITS),
    .QP_BITS  (QP_BITS)
  ) u_front (
    .cmd_i     (qppsn_pkg::cmd_e'(s_axis_tuser)),
    .qp_i      (s_axis_tdata[qppsn_pkg::QP_IN_BITS-1:0]),
    .psn_i     (s_axis_tdata[OFF_PSN +: PSN_BITS]),
    .rpsn_i    (s_axis_tdata[OFF_RPSN +: PSN_BITS]),
    .retry_i   (s_axis_tdata[OFF_RTY +: qppsn_pkg::RETRY_BITS]),
    .ctrl_o    (fr_ctrl),
    .idx_o     (fr_idx),
    .loc_psn_o (fr_loc),
    .req_psn_o (fr_req),
    .retry_o   (fr_retry)
  );

  assign q_push_data = {fr_ctrl, fr_idx, fr_loc, fr_req, fr_retry};

  qppsn_fifo #(
    .DATA_W (Q_W)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (s_axis_tvalid),
    .push_ready_o (s_axis_tready),
    .push_data_i  (q_push_data),
    .pop_valid_o  (q_pop_valid),
    .pop_ready_i  (q_pop_ready),
    .pop_data_o   (q_pop_data)
  );

  assign {bk_ctrl, bk_idx, bk_loc, bk_req, bk_retry} = q_pop_data;

  qppsn_back #(
    .QP_COUNT (QP_COUNT),
    .PSN_BITS (PSN_BITS),
    .QP_BITS  (QP_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (q_pop_valid),
    .in_ready_o    (q_pop_ready),
    .ctrl_i        (bk_ctrl),
    .idx_i         (bk_idx),
    .loc_psn_i     (bk_loc),
    .req_psn_i     (bk_req),
    .retry_i       (bk_retry),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_port_o    (out_port),
    .rx_first_o    (rx_first),
    .rx_second_o   (rx_second),
    .rx_third_o    (rx_third),
    .rx_retry_o    (rx_retry),
    .ent_epsn_o    (ent_epsn),
    .ent_old_out_o (ent_old_out),
    .ent_next_o    (ent_next),
    .ent_unack_o   (ent_unack),
    .ent_valid_o   (ent_valid),
    .ent_retry_o   (ent_retry)
  );

  assign m_axis_tuser = out_port;
  assign m_axis_tdata = OUT_W'({ent_retry, ent_valid, ent_unack, ent_next, ent_old_out,
                                ent_epsn, rx_retry, rx_third, rx_second, rx_first});

endmodule

// ----- sv/qppsn_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qppsn_front
// Classifies a request: reduces the queue pair index and decodes the
// command into write enables, write data and the kind of read.
// ----------------------------------------------------------------------------
module qppsn_front #(
  parameter int unsigned QP_COUNT = 512,
  parameter int unsigned PSN_BITS = 24,
  parameter int unsigned QP_BITS  = 9
) (
  input  qppsn_pkg::cmd_e                  cmd_i,
  input  logic [qppsn_pkg::QP_IN_BITS-1:0] qp_i,
  input  logic [PSN_BITS-1:0]              psn_i,
  input  logic [PSN_BITS-1:0]              rpsn_i,
  input  logic [qppsn_pkg::RETRY_BITS-1:0] retry_i,
  output qppsn_pkg::op_ctrl_t              ctrl_o,
  output logic [QP_BITS-1:0]               idx_o,
  output logic [PSN_BITS-1:0]              loc_psn_o,
  output logic [PSN_BITS-1:0]              req_psn_o,
  output logic [qppsn_pkg::RETRY_BITS-1:0] retry_o
);

  logic [qppsn_pkg::QP_IN_BITS-1:0] rem;

  // index modulo QP_COUNT by shifted compare and subtract
  always_comb begin
    rem = qp_i;
    for (int k = 7; k >= 0; k--) begin
      if ((QP_COUNT << k) <= qppsn_pkg::QP_IN_MAX) begin
        if (rem >= qppsn_pkg::QP_IN_BITS'(QP_COUNT << k)) begin
          rem = rem - qppsn_pkg::QP_IN_BITS'(QP_COUNT << k);
        end
      end
    end
  end

  assign idx_o     = QP_BITS'(rem);
  assign loc_psn_o = psn_i;

  always_comb begin
    ctrl_o    = '0;
    req_psn_o = psn_i;
    retry_o   = retry_i;
    unique case (cmd_i)
      qppsn_pkg::CMD_RX_ACK_WR: begin
        ctrl_o.we.unack = 1'b1;
      end
      qppsn_pkg::CMD_RX_EPSN_WR: begin
        ctrl_o.we.epsn  = 1'b1;
        ctrl_o.we.retry = 1'b1;
      end
      qppsn_pkg::CMD_RX_ACK_RD: begin
        ctrl_o.rd   = qppsn_pkg::RD_RX_ACK;
        ctrl_o.port = qppsn_pkg::PORT_RX;
      end
      qppsn_pkg::CMD_RX_EPSN_RD: begin
        ctrl_o.rd   = qppsn_pkg::RD_RX_EPSN;
        ctrl_o.port = qppsn_pkg::PORT_RX;
      end
      qppsn_pkg::CMD_TX_WR: begin
        ctrl_o.we.next = 1'b1;
      end
      qppsn_pkg::CMD_TX_RD: begin
        ctrl_o.rd   = qppsn_pkg::RD_ENTRY;
        ctrl_o.port = qppsn_pkg::PORT_TX;
      end
      qppsn_pkg::CMD_SETUP: begin
        ctrl_o.we.epsn    = 1'b1;
        ctrl_o.we.old_out = 1'b1;
        ctrl_o.we.next    = 1'b1;
        ctrl_o.we.unack   = 1'b1;
        ctrl_o.we.valid   = 1'b1;
        ctrl_o.we.retry   = 1'b1;
        req_psn_o         = rpsn_i;
        retry_o           = qppsn_pkg::SETUP_RETRY;
      end
      qppsn_pkg::CMD_ENTRY_RD: begin
        ctrl_o.rd   = qppsn_pkg::RD_ENTRY;
        ctrl_o.port = qppsn_pkg::PORT_IF;
      end
      default: begin
        ctrl_o = '0;
      end
    endcase
  end

endmodule

// ----- sv/qppsn_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qppsn_fifo
// Two-entry queue between the request decoder and the table back end.
// ----------------------------------------------------------------------------
module qppsn_fifo #(
  parameter int unsigned DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output logic [DATA_W-1:0] pop_data_o
);

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              push, pop;

  assign push_ready_o = count_q != CNT_W'(DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
    count_d  = count_q + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- sv/qppsn_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qppsn_back
// Table back end: field memories, registered read, reply build and
// output register.
// ----------------------------------------------------------------------------
module qppsn_back #(
  parameter int unsigned QP_COUNT = 512,
  parameter int unsigned PSN_BITS = 24,
  parameter int unsigned QP_BITS  = 9
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  qppsn_pkg::op_ctrl_t              ctrl_i,
  input  logic [QP_BITS-1:0]               idx_i,
  input  logic [PSN_BITS-1:0]              loc_psn_i,
  input  logic [PSN_BITS-1:0]              req_psn_i,
  input  logic [qppsn_pkg::RETRY_BITS-1:0] retry_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output qppsn_pkg::port_e                 out_port_o,
  output logic [PSN_BITS-1:0]              rx_first_o,
  output logic [PSN_BITS-1:0]              rx_second_o,
  output logic [PSN_BITS-1:0]              rx_third_o,
  output logic [qppsn_pkg::RETRY_BITS-1:0] rx_retry_o,
  output logic [PSN_BITS-1:0]              ent_epsn_o,
  output logic [PSN_BITS-1:0]              ent_old_out_o,
  output logic [PSN_BITS-1:0]              ent_next_o,
  output logic [PSN_BITS-1:0]              ent_unack_o,
  output logic [PSN_BITS-1:0]              ent_valid_o,
  output logic [qppsn_pkg::RETRY_BITS-1:0] ent_retry_o
);

  logic [PSN_BITS-1:0]              epsn_mem    [QP_COUNT];
  logic [PSN_BITS-1:0]              old_out_mem [QP_COUNT];
  logic [PSN_BITS-1:0]              next_mem    [QP_COUNT];
  logic [PSN_BITS-1:0]              unack_mem   [QP_COUNT];
  logic [PSN_BITS-1:0]              valid_mem   [QP_COUNT];
  logic [qppsn_pkg::RETRY_BITS-1:0] retry_mem   [QP_COUNT];

  logic [PSN_BITS-1:0]              epsn_rd_q, old_out_rd_q, next_rd_q;
  logic [PSN_BITS-1:0]              unack_rd_q, valid_rd_q;
  logic [qppsn_pkg::RETRY_BITS-1:0] retry_rd_q;

  logic                  s1_valid_q, s1_valid_d;
  qppsn_pkg::rd_kind_e   s1_rd_q;
  qppsn_pkg::port_e      s1_port_q;
  logic                  out_valid_q, out_valid_d;

  logic                  is_read, s1_move, s1_free, pop, rd_en;

  logic [PSN_BITS-1:0]              res_first, res_second, res_third;
  logic [qppsn_pkg::RETRY_BITS-1:0] res_rx_retry;
  logic [PSN_BITS-1:0]              res_epsn, res_old_out, res_next;
  logic [PSN_BITS-1:0]              res_unack, res_valid;
  logic [qppsn_pkg::RETRY_BITS-1:0] res_ent_retry;

  logic [PSN_BITS-1:0]              first_q, second_q, third_q;
  logic [qppsn_pkg::RETRY_BITS-1:0] rx_retry_q;
  logic [PSN_BITS-1:0]              epsn_q, old_out_q, next_q, unack_q, valid_q;
  logic [qppsn_pkg::RETRY_BITS-1:0] ent_retry_q;
  qppsn_pkg::port_e                 port_q;

  assign is_read    = ctrl_i.rd != qppsn_pkg::RD_NONE;
  assign s1_move    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign s1_free    = !s1_valid_q || s1_move;
  // writes drain even while a read reply is held up
  assign in_ready_o = !is_read || s1_free;
  assign pop        = in_valid_i && in_ready_o;
  assign rd_en      = pop && is_read;

  always_ff @(posedge clk_i) begin
    if (pop && ctrl_i.we.epsn) begin
      epsn_mem[idx_i] <= loc_psn_i;
    end
    if (pop && ctrl_i.we.old_out) begin
      old_out_mem[idx_i] <= loc_psn_i;
    end
    if (pop && ctrl_i.we.next) begin
      next_mem[idx_i] <= req_psn_i;
    end
    if (pop && ctrl_i.we.unack) begin
      unack_mem[idx_i] <= req_psn_i;
    end
    if (pop && ctrl_i.we.valid) begin
      valid_mem[idx_i] <= req_psn_i;
    end
    if (pop && ctrl_i.we.retry) begin
      retry_mem[idx_i] <= retry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      epsn_rd_q    <= epsn_mem[idx_i];
      old_out_rd_q <= old_out_mem[idx_i];
      next_rd_q    <= next_mem[idx_i];
      unack_rd_q   <= unack_mem[idx_i];
      valid_rd_q   <= valid_mem[idx_i];
      retry_rd_q   <= retry_mem[idx_i];
    end
  end

  always_comb begin
    if (rd_en) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
    if (s1_move) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s1_rd_q     <= qppsn_pkg::RD_NONE;
      s1_port_q   <= qppsn_pkg::PORT_RX;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (rd_en) begin
        s1_rd_q   <= ctrl_i.rd;
        s1_port_q <= ctrl_i.port;
      end
    end
  end

  // reply build: fields not belonging to the reply kind stay zero
  always_comb begin
    res_first     = '0;
    res_second    = '0;
    res_third     = '0;
    res_rx_retry  = '0;
    res_epsn      = '0;
    res_old_out   = '0;
    res_next      = '0;
    res_unack     = '0;
    res_valid     = '0;
    res_ent_retry = '0;
    unique case (s1_rd_q)
      qppsn_pkg::RD_RX_ACK: begin
        res_first  = unack_rd_q;
        res_second = valid_rd_q;
        res_third  = next_rd_q - PSN_BITS'(1);
      end
      qppsn_pkg::RD_RX_EPSN: begin
        res_first    = epsn_rd_q;
        res_second   = old_out_rd_q;
        res_third    = epsn_rd_q;
        res_rx_retry = retry_rd_q;
      end
      qppsn_pkg::RD_ENTRY: begin
        res_epsn      = epsn_rd_q;
        res_old_out   = old_out_rd_q;
        res_next      = next_rd_q;
        res_unack     = unack_rd_q;
        res_valid     = valid_rd_q;
        res_ent_retry = retry_rd_q;
      end
      default: begin
        res_first = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      port_q      <= s1_port_q;
      first_q     <= res_first;
      second_q    <= res_second;
      third_q     <= res_third;
      rx_retry_q  <= res_rx_retry;
      epsn_q      <= res_epsn;
      old_out_q   <= res_old_out;
      next_q      <= res_next;
      unack_q     <= res_unack;
      valid_q     <= res_valid;
      ent_retry_q <= res_ent_retry;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_port_o    = port_q;
  assign rx_first_o    = first_q;
  assign rx_second_o   = second_q;
  assign rx_third_o    = third_q;
  assign rx_retry_o    = rx_retry_q;
  assign ent_epsn_o    = epsn_q;
  assign ent_old_out_o = old_out_q;
  assign ent_next_o    = next_q;
  assign ent_unack_o   = unack_q;
  assign ent_valid_o   = valid_q;
  assign ent_retry_o   = ent_retry_q;

endmodule

// ----- sv/qppsn_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qppsn_checker
// Port-level checks of the psn state table, bound to the top level.
// ----------------------------------------------------------------------------
module qppsn_checker #(
  parameter int unsigned PSN_BITS = 24
) (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   s_axis_tvalid,
  input logic                                   s_axis_tready,
  input logic [qppsn_pkg::CMD_BITS-1:0]         s_axis_tuser,
  input logic                                   m_axis_tvalid,
  input logic                                   m_axis_tready,
  input logic [((8 * PSN_BITS + 2 * qppsn_pkg::RETRY_BITS + 7) / 8) * 8 - 1:0]
                                                m_axis_tdata,
  input logic [qppsn_pkg::PORT_BITS-1:0]        m_axis_tuser
);

  localparam int unsigned OUT_W = ((8 * PSN_BITS + 2 * qppsn_pkg::RETRY_BITS + 7) / 8) * 8;
  localparam int unsigned RX_W  = 3 * PSN_BITS + qppsn_pkg::RETRY_BITS;

  logic       rd_acc, out_acc;
  logic [2:0] pending_q, pending_d;

  // read requests taken but not yet answered
  assign rd_acc = s_axis_tvalid && s_axis_tready &&
                  (s_axis_tuser == qppsn_pkg::CMD_RX_ACK_RD ||
                   s_axis_tuser == qppsn_pkg::CMD_RX_EPSN_RD ||
                   s_axis_tuser == qppsn_pkg::CMD_TX_RD ||
                   s_axis_tuser == qppsn_pkg::CMD_ENTRY_RD);
  assign out_acc   = m_axis_tvalid && m_axis_tready;
  assign pending_d = pending_q + 3'(rd_acc) - 3'(out_acc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("reply changed while stalled");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> pending_q != 3'd0)
    else $error("reply without a pending read");

  a_rx_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == qppsn_pkg::PORT_RX |->
      m_axis_tdata[OUT_W-1:RX_W] == '0)
    else $error("rx reply carries entry fields");

  a_entry_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid &&
      (m_axis_tuser == qppsn_pkg::PORT_TX || m_axis_tuser == qppsn_pkg::PORT_IF) |->
      m_axis_tdata[RX_W-1:0] == '0)
    else $error("entry reply carries rx fields");

endmodule

bind queue_pair_psn_state_table_unit qppsn_checker #(
  .PSN_BITS (PSN_BITS)
) u_qppsn_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ----- tb/sv/psn_table_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psn_table_checker
// Watches both stream channels of the psn state table, keeps its own copy of
// every queue pair entry, predicts the reply of each read and compares the
// replies field by field, in order.
// ----------------------------------------------------------------------------
module psn_table_checker
  import qppsn_pkg::*;
#(
  parameter int unsigned QP_COUNT = 512,
  parameter int unsigned PSN_BITS = 24
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid_i,
  input  logic                                   s_axis_tready_i,
  // queue_pair, psn_value, remote_psn_value, retry_value
  input  logic [((QP_IN_BITS + 2 * PSN_BITS + RETRY_BITS + 7) / 8) * 8 - 1:0]
                                                 s_axis_tdata_i,
  // command
  input  logic [CMD_BITS-1:0]                    s_axis_tuser_i,
  input  logic                                   m_axis_tvalid_i,
  input  logic                                   m_axis_tready_i,
  // rx_first_psn, rx_second_psn, rx_third_psn, rx_retry, entry_resp_epsn,
  // entry_resp_old_out, entry_req_next, entry_req_unack, entry_req_valid,
  // entry_retry
  input  logic [((8 * PSN_BITS + 2 * RETRY_BITS + 7) / 8) * 8 - 1:0]
                                                 m_axis_tdata_i,
  // dest_port
  input  logic [PORT_BITS-1:0]                   m_axis_tuser_i,
  output int                                     mismatch_count_o,
  output int                                     replies_pending_o,
  output int                                     replies_checked_o
);

  localparam int unsigned P = PSN_BITS;
  localparam int unsigned R = RETRY_BITS;

  typedef logic [P-1:0] psn_t;
  typedef logic [R-1:0] retry_t;

  typedef struct packed {
    port_e  port;
    psn_t   rx_first;
    psn_t   rx_second;
    psn_t   rx_third;
    retry_t rx_retry;
    psn_t   epsn;
    psn_t   old_out;
    psn_t   next;
    psn_t   unack;
    psn_t   valid;
    retry_t retry;
  } psn_reply_t;

  // shadow copy of the table
  psn_t   resp_epsn_q    [QP_COUNT];
  psn_t   resp_old_out_q [QP_COUNT];
  psn_t   req_next_q     [QP_COUNT];
  psn_t   req_unack_q    [QP_COUNT];
  psn_t   req_valid_q    [QP_COUNT];
  retry_t retry_cnt_q    [QP_COUNT];

  psn_reply_t expected_replies[$];

  initial begin
    mismatch_count_o  = 0;
    replies_pending_o = 0;
    replies_checked_o = 0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count_o++;
    $display("%0t mismatch: %s got %h expected %h", $realtime, what, got, want);
  endtask

  task automatic compare_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // applies one request to the shadow table, returns 1 when it reads
  function automatic bit access_psn_table(input cmd_e cmd, input logic [QP_IN_BITS-1:0] qp,
                                          input psn_t psn, input psn_t rpsn,
                                          input retry_t retry, output psn_reply_t reply);
    int unsigned idx;
    idx   = qp % QP_COUNT;
    reply = '0;
    case (cmd)
      CMD_RX_ACK_WR: begin
        req_unack_q[idx] = psn;
        return 1'b0;
      end
      CMD_RX_EPSN_WR: begin
        resp_epsn_q[idx] = psn;
        retry_cnt_q[idx] = retry;
        return 1'b0;
      end
      CMD_TX_WR: begin
        req_next_q[idx] = psn;
        return 1'b0;
      end
      CMD_SETUP: begin
        resp_epsn_q[idx]    = psn;
        resp_old_out_q[idx] = psn;
        req_next_q[idx]     = rpsn;
        req_unack_q[idx]    = rpsn;
        req_valid_q[idx]    = rpsn;
        retry_cnt_q[idx]    = SETUP_RETRY;
        return 1'b0;
      end
      CMD_RX_ACK_RD: begin
        reply.port      = PORT_RX;
        reply.rx_first  = req_unack_q[idx];
        reply.rx_second = req_valid_q[idx];
        // next minus one wraps at the psn width
        reply.rx_third  = req_next_q[idx] - psn_t'(1);
      end
      CMD_RX_EPSN_RD: begin
        reply.port      = PORT_RX;
        reply.rx_first  = resp_epsn_q[idx];
        reply.rx_second = resp_old_out_q[idx];
        reply.rx_third  = resp_epsn_q[idx];
        reply.rx_retry  = retry_cnt_q[idx];
      end
      default: begin
        reply.port    = (cmd == CMD_TX_RD) ? PORT_TX : PORT_IF;
        reply.epsn    = resp_epsn_q[idx];
        reply.old_out = resp_old_out_q[idx];
        reply.next    = req_next_q[idx];
        reply.unack   = req_unack_q[idx];
        reply.valid   = req_valid_q[idx];
        reply.retry   = retry_cnt_q[idx];
      end
    endcase
    return 1'b1;
  endfunction

  task automatic check_reply(input logic [PORT_BITS-1:0] port,
                             input logic [$bits(m_axis_tdata_i)-1:0] d);
    psn_reply_t want;
    if (expected_replies.size() == 0) begin
      report_mismatch("reply with none expected, dest_port", 32'(port), 32'h0);
      return;
    end
    want = expected_replies.pop_front();
    replies_checked_o++;
    compare_field("dest_port", 32'(port), 32'(want.port));
    compare_field("rx_first_psn", 32'(d[0 +: P]), 32'(want.rx_first));
    compare_field("rx_second_psn", 32'(d[P +: P]), 32'(want.rx_second));
    compare_field("rx_third_psn", 32'(d[2*P +: P]), 32'(want.rx_third));
    compare_field("rx_retry", 32'(d[3*P +: R]), 32'(want.rx_retry));
    compare_field("entry_resp_epsn", 32'(d[3*P+R +: P]), 32'(want.epsn));
    compare_field("entry_resp_old_out", 32'(d[4*P+R +: P]), 32'(want.old_out));
    compare_field("entry_req_next", 32'(d[5*P+R +: P]), 32'(want.next));
    compare_field("entry_req_unack", 32'(d[6*P+R +: P]), 32'(want.unack));
    compare_field("entry_req_valid", 32'(d[7*P+R +: P]), 32'(want.valid));
    compare_field("entry_retry", 32'(d[8*P+R +: R]), 32'(want.retry));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    psn_reply_t reply;
    if (!rst_ni) begin
      expected_replies.delete();
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        if (access_psn_table(cmd_e'(s_axis_tuser_i),
                             s_axis_tdata_i[0 +: QP_IN_BITS],
                             s_axis_tdata_i[QP_IN_BITS +: P],
                             s_axis_tdata_i[QP_IN_BITS+P +: P],
                             s_axis_tdata_i[QP_IN_BITS+2*P +: R],
                             reply))
          expected_replies.push_back(reply);
      end
      if (m_axis_tvalid_i && m_axis_tready_i)
        check_reply(m_axis_tuser_i, m_axis_tdata_i);
    end
    replies_pending_o = expected_replies.size();
  end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the psn state table with setups, field writes and all four kinds of
// read, first a directed set of corner values, then random bursts on a small
// pool of queue pairs, while the reply side stalls in changing patterns.
// ----------------------------------------------------------------------------
module tb;

  import qppsn_pkg::*;

  localparam int unsigned QP_COUNT     = 512;
  localparam int unsigned PSN_BITS     = 24;
  localparam int unsigned IN_W         = ((QP_IN_BITS + 2 * PSN_BITS + RETRY_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_W        = ((8 * PSN_BITS + 2 * RETRY_BITS + 7) / 8) * 8;
  localparam int unsigned RANDOM_ITEMS = 450;
  localparam int unsigned POOL_SIZE    = 16;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam logic [PSN_BITS-1:0] PSN_MAX = '1;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_W-1:0]       s_axis_tdata = '0;
  logic [CMD_BITS-1:0]   s_axis_tuser = CMD_RX_ACK_WR;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_W-1:0]      m_axis_tdata;
  logic [PORT_BITS-1:0]  m_axis_tuser;

  int mismatch_count;
  int replies_pending;
  int replies_checked;
  int cycle_count = 0;
  int requests_per_cmd[8];
  bit qp_is_setup[QP_COUNT];
  logic [QP_IN_BITS-1:0] qp_pool[POOL_SIZE];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  queue_pair_psn_state_table_unit #(
    .QP_COUNT (QP_COUNT),
    .PSN_BITS (PSN_BITS)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  psn_table_checker #(
    .QP_COUNT (QP_COUNT),
    .PSN_BITS (PSN_BITS)
  ) i_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .s_axis_tvalid_i   (s_axis_tvalid),
    .s_axis_tready_i   (s_axis_tready),
    .s_axis_tdata_i    (s_axis_tdata),
    .s_axis_tuser_i    (s_axis_tuser),
    .m_axis_tvalid_i   (m_axis_tvalid),
    .m_axis_tready_i   (m_axis_tready),
    .m_axis_tdata_i    (m_axis_tdata),
    .m_axis_tuser_i    (m_axis_tuser),
    .mismatch_count_o  (mismatch_count),
    .replies_pending_o (replies_pending),
    .replies_checked_o (replies_checked)
  );

  // reply side back-pressure in one of four patterns, picked anew at random
  int stall_phase = 0;
  int stall_mode  = 0;
  always @(negedge clk_i) begin
    stall_phase++;
    if (stall_phase % 48 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0:       m_axis_tready = 1'b1;
      1:       m_axis_tready = 1'($urandom_range(0, 1));
      2:       m_axis_tready = ($urandom_range(0, 3) == 0);
      default: m_axis_tready = ((stall_phase % 8) < 4);
    endcase
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies outstanding",
               cycle_count, replies_pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // starts and ends at a falling edge
  task automatic send_request(input cmd_e cmd, input logic [QP_IN_BITS-1:0] qp,
                              input logic [PSN_BITS-1:0] psn,
                              input logic [PSN_BITS-1:0] rpsn,
                              input logic [RETRY_BITS-1:0] retry);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = IN_W'({retry, rpsn, psn, qp});
    s_axis_tuser  = cmd;
    requests_per_cmd[cmd]++;
    if (cmd == CMD_SETUP) qp_is_setup[qp % QP_COUNT] = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic pause_sender(input int cycles);
    s_axis_tvalid = 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  task automatic wait_replies_drained();
    s_axis_tvalid = 1'b0;
    do @(negedge clk_i); while (replies_pending != 0);
  endtask

  task automatic send_random_request();
    logic [QP_IN_BITS-1:0] qp;
    cmd_e cmd;
    qp  = ($urandom_range(0, 3) == 0) ? QP_IN_BITS'($urandom_range(0, QP_IN_MAX))
                                       : qp_pool[$urandom_range(0, POOL_SIZE - 1)];
    cmd = cmd_e'($urandom_range(0, 7));
    // entries are only read once set up
    if (!qp_is_setup[qp % QP_COUNT] && (cmd == CMD_RX_ACK_RD || cmd == CMD_RX_EPSN_RD ||
                                        cmd == CMD_TX_RD || cmd == CMD_ENTRY_RD))
      cmd = CMD_SETUP;
    send_request(cmd, qp, PSN_BITS'($urandom), PSN_BITS'($urandom),
                 RETRY_BITS'($urandom_range(0, 15)));
  endtask

  initial begin
    int sent;
    int burst;
    bit mid_drain_done;
    sent = 0;
    mid_drain_done = 1'b0;
    qp_pool[0] = '0;
    qp_pool[1] = QP_IN_BITS'(QP_IN_MAX);
    for (int i = 2; i < POOL_SIZE; i++) qp_pool[i] = QP_IN_BITS'($urandom_range(0, QP_IN_MAX));

    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed corners, back to back
    send_request(CMD_SETUP, '0, '0, '0, '0);
    send_request(CMD_RX_ACK_RD, '0, '0, '0, '0);         // next psn zero wraps
    send_request(CMD_RX_EPSN_RD, '0, '0, '0, '0);
    send_request(CMD_SETUP, QP_IN_BITS'(QP_IN_MAX), PSN_MAX, PSN_MAX, 4'hF);
    send_request(CMD_ENTRY_RD, QP_IN_BITS'(QP_IN_MAX), '0, '0, '0);
    send_request(CMD_TX_RD, QP_IN_BITS'(QP_IN_MAX), '0, '0, '0);
    send_request(CMD_RX_ACK_RD, QP_IN_BITS'(QP_IN_MAX), '0, '0, '0);
    send_request(CMD_RX_EPSN_WR, QP_IN_BITS'(QP_IN_MAX), 24'h123456, PSN_MAX, 4'h0);
    send_request(CMD_RX_EPSN_RD, QP_IN_BITS'(QP_IN_MAX), '0, '0, '0);
    send_request(CMD_RX_EPSN_WR, '0, PSN_MAX, '0, 4'hF);
    send_request(CMD_RX_EPSN_RD, '0, '0, '0, '0);
    send_request(CMD_RX_ACK_WR, '0, PSN_MAX, '0, '0);
    send_request(CMD_TX_WR, '0, 24'h000001, '0, '0);
    send_request(CMD_RX_ACK_RD, '0, '0, '0, '0);          // next minus one is zero
    send_request(CMD_TX_WR, '0, '0, PSN_MAX, 4'hA);
    send_request(CMD_RX_ACK_RD, '0, '0, '0, '0);
    send_request(CMD_ENTRY_RD, '0, '0, '0, '0);
    send_request(CMD_TX_RD, '0, '0, '0, '0);
    send_request(CMD_SETUP, 9'h155, 24'hAAAAAA, 24'h555555, 4'h5);
    send_request(CMD_ENTRY_RD, 9'h155, '0, '0, '0);
    send_request(CMD_RX_ACK_WR, 9'h0AA, 24'h5A5A5A, '0, '0);  // write to an entry never set up
    send_request(CMD_TX_WR, 9'h0AA, 24'hA5A5A5, '0, '0);
    send_request(CMD_SETUP, 9'h0AA, 24'h0F0F0F, 24'hF0F0F0, '0);
    send_request(CMD_RX_ACK_RD, 9'h0AA, '0, '0, '0);
    wait_replies_drained();

    // random bursts, with one full drain half way through
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst && sent < RANDOM_ITEMS; b++) begin
        send_random_request();
        sent++;
      end
      if (!mid_drain_done && sent >= RANDOM_ITEMS / 2) begin
        wait_replies_drained();
        mid_drain_done = 1'b1;
      end else if ($urandom_range(0, 3) != 0) begin
        pause_sender($urandom_range(1, 8));
      end
    end

    wait_replies_drained();
    repeat (20) @(negedge clk_i);

    $display("sent %0d setups, %0d field writes and %0d reads",
             requests_per_cmd[CMD_SETUP],
             requests_per_cmd[CMD_RX_ACK_WR] + requests_per_cmd[CMD_RX_EPSN_WR] +
             requests_per_cmd[CMD_TX_WR],
             requests_per_cmd[CMD_RX_ACK_RD] + requests_per_cmd[CMD_RX_EPSN_RD] +
             requests_per_cmd[CMD_TX_RD] + requests_per_cmd[CMD_ENTRY_RD]);
    $display("checked %0d replies on rx, tx and interface ports, %0d mismatches",
             replies_checked, mismatch_count);
    if (mismatch_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
